[hdl/hbrp_pkg.sv]
package hbrp_pkg;

    localparam int PREFIX_LEN  = 6;
    localparam int PFX_IDX_W   = 3;
    localparam int VALUE_W     = 64;
    localparam int OUT_DEPTH   = 4;
    localparam int OUT_PTR_W   = 2;
    localparam int OUT_CNT_W   = 3;
    localparam int M_TDATA_W   = 136;

    localparam logic [7:0] CHAR_COMMA = 8'h2c;
    localparam logic [7:0] CHAR_DASH  = 8'h2d;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic KIND_RANGE  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;
    localparam logic MODE_CHAR   = 1'b0;
    localparam logic MODE_END    = 1'b1;

    typedef enum logic [3:0] {
        HDR_LEAD   = 4'b0001,
        HDR_PREFIX = 4'b0010,
        HDR_SPECS  = 4'b0100,
        HDR_REJECT = 4'b1000
    } hdr_state_t;

    typedef enum logic [5:0] {
        SP_BEFORE_LEFT  = 6'b000001,
        SP_IN_LEFT      = 6'b000010,
        SP_AFTER_LEFT   = 6'b000100,
        SP_BEFORE_RIGHT = 6'b001000,
        SP_IN_RIGHT     = 6'b010000,
        SP_AFTER_RIGHT  = 6'b100000
    } spec_phase_t;

    typedef struct packed {
        spec_phase_t          phase;
        logic [VALUE_W-1:0]   left_value;
        logic                 left_has_digits;
        logic [VALUE_W-1:0]   right_value;
        logic                 right_has_digits;
        logic                 nonblank;
        logic                 bad;
    } spec_t;

    typedef struct packed {
        logic                 kind;
        logic [VALUE_W-1:0]   range_start;
        logic [VALUE_W-1:0]   range_end;
        logic                 present;
        logic                 unsatisfiable;
        logic                 last;
    } result_t;

    typedef struct packed {
        logic                 ok;
        logic [VALUE_W-1:0]   range_start;
        logic [VALUE_W-1:0]   range_end;
    } resolve_t;

    localparam spec_t SPEC_CLEAR = '{
        phase: SP_BEFORE_LEFT,
        left_value: '0,
        left_has_digits: 1'b0,
        right_value: '0,
        right_has_digits: 1'b0,
        nonblank: 1'b0,
        bad: 1'b0
    };

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5a) begin
            return c + 8'd32;
        end
        return c;
    endfunction

    function automatic logic [7:0] unit_char(input logic [PFX_IDX_W-1:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h62;
            3'd1:    c = 8'h79;
            3'd2:    c = 8'h74;
            3'd3:    c = 8'h65;
            3'd4:    c = 8'h73;
            3'd5:    c = 8'h3d;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // v*10 + d as shift-add; bit VALUE_W flags overflow
    function automatic logic [VALUE_W:0] acc_digit(input logic [VALUE_W-1:0] v,
                                                   input logic [3:0] d);
        logic [VALUE_W+3:0] sum;
        sum = ({4'b0, v} << 3) + ({4'b0, v} << 1) + {{VALUE_W{1'b0}}, d};
        return {|sum[VALUE_W+3:VALUE_W], sum[VALUE_W-1:0]};
    endfunction

endpackage

[hdl/hbrp_resolve.sv]
module hbrp_resolve
    import hbrp_pkg::*;
(
    input  spec_t              spec,
    input  logic [VALUE_W-1:0] size_bytes,
    output resolve_t           res
);

    logic               right_phase;
    logic               size_nz;
    logic [VALUE_W-1:0] size_m1;
    logic [VALUE_W-1:0] suffix_cnt;
    logic               suffix_ok;
    logic               open_ok;

    assign right_phase = (spec.phase == SP_BEFORE_RIGHT) || (spec.phase == SP_IN_RIGHT)
                      || (spec.phase == SP_AFTER_RIGHT);
    assign size_nz     = |size_bytes;
    assign size_m1     = size_bytes - VALUE_W'(1);
    assign suffix_cnt  = (spec.right_value > size_bytes) ? size_bytes : spec.right_value;
    assign suffix_ok   = !spec.left_has_digits && spec.right_has_digits
                      && (|spec.right_value);
    assign open_ok     = spec.left_has_digits && (spec.left_value < size_bytes)
                      && (!spec.right_has_digits || spec.right_value >= spec.left_value);

    always_comb begin
        res.ok = spec.nonblank && !spec.bad && right_phase && size_nz
              && (suffix_ok || open_ok);
        if (!spec.left_has_digits) begin
            res.range_start = size_bytes - suffix_cnt;
            res.range_end   = size_m1;
        end else begin
            res.range_start = spec.left_value;
            if (!spec.right_has_digits || spec.right_value >= size_bytes) begin
                res.range_end = size_m1;
            end else begin
                res.range_end = spec.right_value;
            end
        end
    end

endmodule

[hdl/hbrp_out_fifo.sv]
module hbrp_out_fifo
    import hbrp_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [1:0]    push_n,
    input  result_t       push_a,
    input  result_t       push_b,
    output logic          room_two,
    output logic          out_valid,
    input  logic          out_ready,
    output result_t       out_data
);

    result_t                mem [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [OUT_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [OUT_CNT_W-1:0]   count_reg, count_next;
    logic                   pop;

    assign out_valid = |count_reg;
    assign out_data  = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign room_two  = count_reg <= OUT_CNT_W'(OUT_DEPTH - 2);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + OUT_PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + OUT_PTR_W'(pop);
        count_next  = count_reg + OUT_CNT_W'(push_n) - OUT_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            mem[wr_ptr_reg] <= push_a;
        end
        if (push_n == 2'd2) begin
            mem[wr_ptr_reg + OUT_PTR_W'(1)] <= push_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[hdl/http_byte_range_parser.sv]
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tdata: char_byte; tuser: mode
// m_*       out  m_tvalid/m_tready  tdata: range_start, range_end, present,
//                                   unsatisfiable; tuser: kind; tlast: last
// cfg_*     in   cfg_we             cfg_wdata: object size in bytes
//
// One character per cycle. A character is latched in an input register, parsed
// from there, and its results (at most two) land in a 4-entry output queue.
// Input stalls only when the queue has fewer than two free entries.
// Reset is synchronous and clears parser state, the size register and the queue.
module http_byte_range_parser
    import hbrp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [VALUE_W-1:0]    cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] char_byte
    input  logic                  s_tuser,   // [0] mode
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [63:0] range_start, [127:64] range_end,
                                             // [128] present, [129] unsatisfiable
    output logic                  m_tuser,   // [0] kind
    output logic                  m_tlast
);

    logic [VALUE_W-1:0]   size_reg;
    logic                 in_valid_reg;
    logic                 in_mode_reg;
    logic [7:0]           in_char_reg;

    hdr_state_t           hdr_reg, hdr_next;
    logic [PFX_IDX_W-1:0] pfx_reg, pfx_next;
    spec_t                spec_reg, spec_next;
    logic                 seen_reg, seen_next;
    logic                 emitted_reg, emitted_next;

    logic                 fire;
    logic                 room_two;
    resolve_t             res;
    logic [1:0]           push_n;
    result_t              push_a, push_b;
    result_t              out_data;
    result_t              range_res, status_res;
    logic [3:0]           digit;
    logic                 is_digit;
    logic [VALUE_W:0]     left_acc, right_acc;
    logic [PFX_IDX_W-1:0] idx;
    logic                 seen_eff, emitted_eff;

    assign fire     = in_valid_reg && room_two;
    assign s_tready = !in_valid_reg || fire;

    hbrp_resolve u_resolve (
        .spec       (spec_reg),
        .size_bytes (size_reg),
        .res        (res)
    );

    hbrp_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_n    (push_n),
        .push_a    (push_a),
        .push_b    (push_b),
        .room_two  (room_two),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = {6'b0, out_data.unsatisfiable, out_data.present,
                      out_data.range_end, out_data.range_start};
    assign m_tuser = out_data.kind;
    assign m_tlast = out_data.last;

    assign digit       = 4'(in_char_reg - CHAR_ZERO);
    assign is_digit    = (in_char_reg >= CHAR_ZERO) && (in_char_reg <= CHAR_NINE);
    assign left_acc    = acc_digit(spec_reg.left_value, digit);
    assign right_acc   = acc_digit(spec_reg.right_value, digit);
    assign idx         = (hdr_reg == HDR_LEAD) ? '0 : pfx_reg;
    assign seen_eff    = seen_reg || spec_reg.nonblank;
    assign emitted_eff = emitted_reg || res.ok;

    always_comb begin
        range_res = '{kind: KIND_RANGE, range_start: res.range_start,
                      range_end: res.range_end, present: 1'b0,
                      unsatisfiable: 1'b0, last: 1'b0};
        status_res = '{kind: KIND_STATUS, range_start: '0, range_end: '0,
                       present: 1'b0, unsatisfiable: 1'b0, last: 1'b1};
        if (hdr_reg == HDR_SPECS) begin
            status_res.present       = seen_eff;
            status_res.unsatisfiable = seen_eff && !emitted_eff;
        end
    end

    always_comb begin
        hdr_next     = hdr_reg;
        pfx_next     = pfx_reg;
        spec_next    = spec_reg;
        seen_next    = seen_reg;
        emitted_next = emitted_reg;
        push_n       = 2'd0;
        push_a       = range_res;
        push_b       = status_res;
        if (fire) begin
            if (in_mode_reg == MODE_END) begin
                if (hdr_reg == HDR_SPECS && res.ok) begin
                    push_n = 2'd2;
                end else begin
                    push_n = 2'd1;
                    push_a = status_res;
                end
                hdr_next     = HDR_LEAD;
                pfx_next     = '0;
                spec_next    = SPEC_CLEAR;
                seen_next    = 1'b0;
                emitted_next = 1'b0;
            end else begin
                unique case (hdr_reg)
                    HDR_LEAD, HDR_PREFIX: begin
                        if (!(hdr_reg == HDR_LEAD && is_ws(in_char_reg))) begin
                            if (to_lower(in_char_reg) == unit_char(idx)) begin
                                if (idx == PFX_IDX_W'(PREFIX_LEN - 1)) begin
                                    hdr_next = HDR_SPECS;
                                end else begin
                                    hdr_next = HDR_PREFIX;
                                    pfx_next = idx + PFX_IDX_W'(1);
                                end
                            end else begin
                                hdr_next = HDR_REJECT;
                            end
                        end
                    end
                    HDR_SPECS: begin
                        if (in_char_reg == CHAR_COMMA) begin
                            push_n       = {1'b0, res.ok};
                            seen_next    = seen_eff;
                            emitted_next = emitted_eff;
                            spec_next    = SPEC_CLEAR;
                        end else if (is_ws(in_char_reg)) begin
                            if (spec_reg.phase == SP_IN_LEFT) begin
                                spec_next.phase = SP_AFTER_LEFT;
                            end else if (spec_reg.phase == SP_IN_RIGHT) begin
                                spec_next.phase = SP_AFTER_RIGHT;
                            end
                        end else begin
                            spec_next.nonblank = 1'b1;
                            if (!spec_reg.bad) begin
                                if (is_digit) begin
                                    if (spec_reg.phase == SP_BEFORE_LEFT
                                        || spec_reg.phase == SP_IN_LEFT) begin
                                        spec_next.left_value      = left_acc[VALUE_W-1:0];
                                        spec_next.bad             = left_acc[VALUE_W];
                                        spec_next.left_has_digits = 1'b1;
                                        spec_next.phase           = SP_IN_LEFT;
                                    end else if (spec_reg.phase == SP_BEFORE_RIGHT
                                                 || spec_reg.phase == SP_IN_RIGHT) begin
                                        spec_next.right_value      = right_acc[VALUE_W-1:0];
                                        spec_next.bad              = right_acc[VALUE_W];
                                        spec_next.right_has_digits = 1'b1;
                                        spec_next.phase            = SP_IN_RIGHT;
                                    end else begin
                                        spec_next.bad = 1'b1;
                                    end
                                end else if (in_char_reg == CHAR_DASH) begin
                                    if (spec_reg.phase == SP_BEFORE_LEFT
                                        || spec_reg.phase == SP_IN_LEFT
                                        || spec_reg.phase == SP_AFTER_LEFT) begin
                                        spec_next.phase = SP_BEFORE_RIGHT;
                                    end else begin
                                        spec_next.bad = 1'b1;
                                    end
                                end else begin
                                    spec_next.bad = 1'b1;
                                end
                            end
                        end
                    end
                    HDR_REJECT: begin
                    end
                    default: begin
                        hdr_next = HDR_REJECT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg     <= '0;
            in_valid_reg <= 1'b0;
            in_mode_reg  <= 1'b0;
            in_char_reg  <= '0;
            hdr_reg      <= HDR_LEAD;
            pfx_reg      <= '0;
            spec_reg     <= SPEC_CLEAR;
            seen_reg     <= 1'b0;
            emitted_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                size_reg <= cfg_wdata;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
                in_mode_reg  <= s_tuser;
                in_char_reg  <= s_tdata;
            end
            hdr_reg     <= hdr_next;
            pfx_reg     <= pfx_next;
            spec_reg    <= spec_next;
            seen_reg    <= seen_next;
            emitted_reg <= emitted_next;
        end
    end

endmodule
